// ===== hdl/pcs_pkg.sv =====
// Shared types, character codes and the per-byte scan step for the comment stripper.
package pcs_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [8:0] {
        M_PLAIN = 9'b000000001,
        M_QUOTE = 9'b000000010,
        M_SLASH = 9'b000000100,
        M_BRACE = 9'b000001000,
        M_PAREN = 9'b000010000,
        M_NL    = 9'b000100000,
        M_LINE  = 9'b001000000,
        M_BLOCK = 9'b010000000,
        M_BSTAR = 9'b100000000
    } mode_t;

    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } res_t;

    typedef struct packed {
        mode_t      mode;
        logic       prev_nl;
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } step_t;

    typedef struct packed {
        mode_t mode;
        logic  emit;
    } plain_t;

    function automatic plain_t plain_step(input logic [7:0] c);
        plain_t p;
        p.emit = 1'b0;
        case (c)
            CH_QUOTE: begin
                p.mode = M_QUOTE;
                p.emit = 1'b1;
            end
            CH_SLASH:  p.mode = M_SLASH;
            CH_LBRACE: p.mode = M_BRACE;
            CH_LPAREN: p.mode = M_PAREN;
            CH_NL:     p.mode = M_NL;
            default: begin
                p.mode = M_PLAIN;
                p.emit = 1'b1;
            end
        endcase
        return p;
    endfunction

    function automatic step_t scan_step(input mode_t mode, input logic prev_nl,
                                        input logic [7:0] c);
        step_t      s;
        plain_t     p;
        logic       c0_v;
        logic [7:0] c0_c;
        logic       c1_v;
        logic       k0;
        logic       k1;
        logic       pn;
        p    = plain_step(c);
        c0_v = 1'b0;
        c0_c = c;
        c1_v = 1'b0;
        s.mode = mode;
        case (mode)
            M_QUOTE: begin
                if (c == CH_QUOTE) s.mode = M_PLAIN;
                c0_v = 1'b1;
            end
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    s.mode = M_LINE;
                end else begin
                    c0_v   = 1'b1;
                    c0_c   = CH_SLASH;
                    c1_v   = p.emit;
                    s.mode = p.mode;
                end
            end
            M_BRACE: begin
                if (c == CH_RBRACE) s.mode = M_PLAIN;
            end
            M_PAREN: begin
                if (c == CH_STAR) begin
                    s.mode = M_BLOCK;
                end else begin
                    c0_v   = 1'b1;
                    c0_c   = CH_LPAREN;
                    c1_v   = p.emit;
                    s.mode = p.mode;
                end
            end
            M_NL: begin
                if (c != CH_NL) begin
                    c0_v   = 1'b1;
                    c0_c   = CH_NL;
                    c1_v   = p.emit;
                    s.mode = p.mode;
                end
            end
            M_LINE: begin
                if (c == CH_NL) begin
                    c0_v   = 1'b1;
                    c0_c   = CH_NL;
                    s.mode = M_NL;
                end
            end
            M_BLOCK: begin
                if (c == CH_STAR) s.mode = M_BSTAR;
            end
            M_BSTAR: begin
                if (c == CH_RPAREN) s.mode = M_PLAIN;
                else if (c != CH_STAR) s.mode = M_BLOCK;
            end
            default: begin
                c0_v   = p.emit;
                s.mode = p.mode;
            end
        endcase
        // drop a newline that follows a newline (or the start of output)
        pn = prev_nl;
        k0 = c0_v && !((c0_c == CH_NL) && pn);
        if (k0) pn = (c0_c == CH_NL);
        k1 = c1_v && !((c == CH_NL) && pn);
        if (k1) pn = (c == CH_NL);
        s.prev_nl = pn;
        s.count   = {1'b0, k0} + {1'b0, k1};
        s.r0.ch   = k0 ? c0_c : c;
        s.r0.last = !(k0 && k1);
        s.r1.ch   = c;
        s.r1.last = 1'b1;
        return s;
    endfunction

endpackage

// ===== hdl/pascal_comment_stripper.sv =====
// Top level of the Pascal comment stripper: input register, scan step and result queue.
// Strips brace, (* *) and // comments from a byte stream, passes quoted literals as they
// are and collapses newline runs. Each accepted byte waits in the input register until
// the queue has room for two results, is then scanned and yields zero, one or two result
// bytes, which enter a four-entry queue; the last byte caused by an input carries m_tlast.
// One result leaves per cycle while m_tready is high, so the block sustains one input per
// cycle while inputs yield at most one byte each; when every input yields two, the single
// result port limits the input rate. A pending '/', '(' or newline is held until the next
// byte arrives.
module pascal_comment_stripper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // last_of_run
);

    logic                       in_valid_reg;
    logic [7:0]                 in_data_reg;
    pcs_pkg::mode_t             mode_reg;
    logic                       prev_nl_reg;
    pcs_pkg::res_t              mem [pcs_pkg::FIFO_DEPTH];
    logic [pcs_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [pcs_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [pcs_pkg::FIFO_CW-1:0] count_reg;
    logic [pcs_pkg::FIFO_CW-1:0] count_next;
    pcs_pkg::step_t             step;
    logic                       consume;
    logic                       pop;
    logic                       s_xfer;

    assign step    = pcs_pkg::scan_step(mode_reg, prev_nl_reg, in_data_reg);
    assign consume = in_valid_reg &&
                     (count_reg <= pcs_pkg::FIFO_CW'(pcs_pkg::FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || consume;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = mem[rd_ptr_reg].ch;
    assign m_tlast  = mem[rd_ptr_reg].last;

    always_comb begin
        count_next = count_reg;
        if (consume) count_next = count_next + pcs_pkg::FIFO_CW'(step.count);
        if (pop)     count_next = count_next - pcs_pkg::FIFO_CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= pcs_pkg::M_PLAIN;
            prev_nl_reg  <= 1'b1;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                mode_reg    <= step.mode;
                prev_nl_reg <= step.prev_nl;
                wr_ptr_reg  <= wr_ptr_reg + pcs_pkg::FIFO_AW'(step.count);
            end
            if (pop) rd_ptr_reg <= rd_ptr_reg + pcs_pkg::FIFO_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) in_data_reg <= s_tdata;
        if (consume && (step.count != 2'd0)) mem[wr_ptr_reg] <= step.r0;
        if (consume && (step.count == 2'd2)) begin
            mem[wr_ptr_reg + pcs_pkg::FIFO_AW'(1)] <= step.r1;
        end
    end

endmodule

// ===== hdl/pcs_checker.sv =====
// Port-level checks for the comment stripper and their bind to the top level.
module pcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic last_nl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_nl_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            last_nl_reg <= (m_tdata == pcs_pkg::CH_NL);
        end
    end

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_no_double_nl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tdata == pcs_pkg::CH_NL) |-> !last_nl_reg)
        else $error("newline transfer after newline or at start of output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind pascal_comment_stripper pcs_checker u_pcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== dv/testbench.sv =====
// Testbench for the Pascal comment stripper: byte stream stimulus, scoreboard and checks.
module testbench;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_BYTES  = 360;
    localparam logic [7:0] SPECIALS [8] = '{pcs_pkg::CH_QUOTE, pcs_pkg::CH_SLASH,
                                            pcs_pkg::CH_LBRACE, pcs_pkg::CH_RBRACE,
                                            pcs_pkg::CH_LPAREN, pcs_pkg::CH_STAR,
                                            pcs_pkg::CH_RPAREN, pcs_pkg::CH_NL};

    class strip_scoreboard;
        pcs_pkg::mode_t mode;
        bit             prev_nl;
        pcs_pkg::res_t  step_q[$];
        pcs_pkg::res_t  expected_q[$];
        int             errors;

        function new();
            mode    = pcs_pkg::M_PLAIN;
            prev_nl = 1'b1;
            errors  = 0;
        endfunction

        // drop a newline right after a newline or at the start of output
        function void pass_byte(logic [7:0] c);
            pcs_pkg::res_t r;
            if (c == pcs_pkg::CH_NL && prev_nl) return;
            prev_nl = (c == pcs_pkg::CH_NL);
            r.ch    = c;
            r.last  = 1'b0;
            step_q  = {step_q, r};
        endfunction

        function void scan_plain(logic [7:0] c);
            case (c)
                pcs_pkg::CH_QUOTE: begin
                    mode = pcs_pkg::M_QUOTE;
                    pass_byte(c);
                end
                pcs_pkg::CH_SLASH:  mode = pcs_pkg::M_SLASH;
                pcs_pkg::CH_LBRACE: mode = pcs_pkg::M_BRACE;
                pcs_pkg::CH_LPAREN: mode = pcs_pkg::M_PAREN;
                pcs_pkg::CH_NL:     mode = pcs_pkg::M_NL;
                default: begin
                    mode = pcs_pkg::M_PLAIN;
                    pass_byte(c);
                end
            endcase
        endfunction

        function void note_input(logic [7:0] c);
            step_q.delete();
            case (mode)
                pcs_pkg::M_QUOTE: begin
                    if (c == pcs_pkg::CH_QUOTE) mode = pcs_pkg::M_PLAIN;
                    pass_byte(c);
                end
                pcs_pkg::M_SLASH: begin
                    if (c == pcs_pkg::CH_SLASH) begin
                        mode = pcs_pkg::M_LINE;
                    end else begin
                        pass_byte(pcs_pkg::CH_SLASH);
                        scan_plain(c);
                    end
                end
                pcs_pkg::M_BRACE: begin
                    if (c == pcs_pkg::CH_RBRACE) mode = pcs_pkg::M_PLAIN;
                end
                pcs_pkg::M_PAREN: begin
                    if (c == pcs_pkg::CH_STAR) begin
                        mode = pcs_pkg::M_BLOCK;
                    end else begin
                        pass_byte(pcs_pkg::CH_LPAREN);
                        scan_plain(c);
                    end
                end
                pcs_pkg::M_NL: begin
                    if (c != pcs_pkg::CH_NL) begin
                        pass_byte(pcs_pkg::CH_NL);
                        scan_plain(c);
                    end
                end
                pcs_pkg::M_LINE: begin
                    if (c == pcs_pkg::CH_NL) begin
                        pass_byte(pcs_pkg::CH_NL);
                        scan_plain(c);
                    end
                end
                pcs_pkg::M_BLOCK: begin
                    if (c == pcs_pkg::CH_STAR) mode = pcs_pkg::M_BSTAR;
                end
                pcs_pkg::M_BSTAR: begin
                    if (c == pcs_pkg::CH_RPAREN) mode = pcs_pkg::M_PLAIN;
                    else if (c != pcs_pkg::CH_STAR) mode = pcs_pkg::M_BLOCK;
                end
                default: scan_plain(c);
            endcase
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
            expected_q = {expected_q, step_q};
        endfunction

        function void check_output(logic [7:0] ch, logic last);
            pcs_pkg::res_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                         $time, ch, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (want.ch !== ch) begin
                $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    strip_scoreboard board = new();
    logic [7:0] text_q[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_done     = 0;
    int hold_cnt       = 0;
    int idle_cycles    = 0;

    pascal_comment_stripper dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) board.check_output(m_tdata, m_tlast);
        if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            hold_cnt   = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_char();
        if ($urandom_range(99) < 40) return SPECIALS[$urandom_range(7)];
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] content_char(logic [7:0] excluded);
        logic [7:0] c;
        do c = rand_char(); while (c == excluded);
        return c;
    endfunction

    function automatic void add_char(logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    task automatic send_byte(input logic [7:0] c);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(c);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task automatic add_token();
        int kind;
        int n;
        kind = $urandom_range(99);
        n    = $urandom_range(1, 5);
        if (kind < 25) begin
            repeat (n) add_char(8'($urandom_range(8'h20, 8'h7E)));
        end else if (kind < 40) begin
            add_char(pcs_pkg::CH_QUOTE);
            repeat (n - 1) add_char(content_char(pcs_pkg::CH_QUOTE));
            add_char(pcs_pkg::CH_QUOTE);
        end else if (kind < 50) begin
            add_char(pcs_pkg::CH_LBRACE);
            repeat (n) add_char(content_char(pcs_pkg::CH_RBRACE));
            add_char(pcs_pkg::CH_RBRACE);
        end else if (kind < 60) begin
            add_char(pcs_pkg::CH_LPAREN);
            add_char(pcs_pkg::CH_STAR);
            repeat (n) add_char(content_char(pcs_pkg::CH_RPAREN));
            add_char(pcs_pkg::CH_STAR);
            add_char(pcs_pkg::CH_RPAREN);
        end else if (kind < 70) begin
            add_char(pcs_pkg::CH_SLASH);
            add_char(pcs_pkg::CH_SLASH);
            repeat (n) add_char(content_char(pcs_pkg::CH_NL));
            add_char(pcs_pkg::CH_NL);
        end else if (kind < 80) begin
            repeat (n) add_char(pcs_pkg::CH_NL);
        end else if (kind < 88) begin
            add_char($urandom_range(1) ? pcs_pkg::CH_SLASH : pcs_pkg::CH_LPAREN);
            add_char(rand_char());
        end else begin
            repeat (n) add_char(8'($urandom_range(255)));
        end
    endtask

    initial begin
        string opening;
        opening = "\na'\nx'/b//z\n\n(**)(q{c}";
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < opening.len(); i++) send_byte(opening[i]);
        send_byte(8'h00);
        send_byte(8'hFF);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            text_q.delete();
            while (text_q.size() < PHASE_BYTES) add_token();
            if (phase == 0) holds_asked++;
            foreach (text_q[i]) send_byte(text_q[i]);
            drain();
        end

        repeat (8) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
